// ===== src/bsms_pkg.sv =====
// Package for the bit string move and search engine.
// Holds result kinds, operation codes and the control state encoding.
`default_nettype none
package bsms_pkg;
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    localparam logic       OP_START = 1'b0;
    localparam logic       OP_DATA  = 1'b1;

    localparam logic [2:0] XF_OR   = 3'd0;
    localparam logic [2:0] XF_AND  = 3'd1;
    localparam logic [2:0] XF_XOR  = 3'd2;
    localparam logic [2:0] XF_MOV  = 3'd3;
    localparam logic [2:0] XF_ORN  = 3'd4;
    localparam logic [2:0] XF_ANDN = 3'd5;
    localparam logic [2:0] XF_XORN = 3'd6;
    localparam logic [2:0] XF_NOT  = 3'd7;

    localparam logic [31:0] WORD_STEP = 32'd4;
    localparam logic [31:0] ADDR_MASK = 32'hFFFF_FFFC;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_WSRC  = 5'b00010,
        ST_WDST  = 5'b00100,
        ST_RUN   = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;
endpackage
`default_nettype wire

// ===== src/bit_string_move_and_search_top.sv =====
// Top level of the bit string move and search engine.
// Depends on bsms_pkg.
//
// channel | direction | handshake          | payload
// request | in        | in_valid/in_stall  | op, operation, offsets, count, addresses, word
// result  | out       | out_valid/out_stall| kind, mem_address, write_data, final_*, last
//
// The scan loop over the source and destination words processes one bit per cycle
// while the output register is free and the words that it needs are loaded.
// Each result is held in the output register.
// Reset clears the control state; the block comes up idle.
// A stalled result holds; the input stalls while a result waits or a bit run is active.
`default_nettype none
module bit_string_move_and_search_top
    import bsms_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        op,
    input  wire logic [3:0]  operation,
    input  wire logic [4:0]  dest_bit_offset,
    input  wire logic [4:0]  source_bit_offset,
    input  wire logic [31:0] bit_count,
    input  wire logic [31:0] dest_word_address,
    input  wire logic [31:0] source_word_address,
    input  wire logic [31:0] skipped_start,
    input  wire logic [31:0] read_word,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       kind,
    output logic [31:0]      mem_address,
    output logic [31:0]      write_data,
    output logic [4:0]       final_dest_offset,
    output logic [4:0]       final_source_offset,
    output logic [31:0]      final_count,
    output logic [31:0]      final_dest_address,
    output logic [31:0]      final_source_address,
    output logic [31:0]      final_skipped,
    output logic             zero_flag,
    output logic             last
);
    state_t      state_reg, state_next;
    logic [3:0]  oper_reg, oper_next;
    logic [31:0] src_reg, src_next, dst_reg, dst_next;
    logic        sv_reg, sv_next, dv_reg, dv_next;
    logic [4:0]  doff_reg, doff_next, soff_reg, soff_next;
    logic [31:0] cnt_reg, cnt_next, daddr_reg, daddr_next;
    logic [31:0] saddr_reg, saddr_next, skip_reg, skip_next;
    logic        zf_reg, zf_next;

    logic        ov_reg, ov_next;
    logic [1:0]  kind_reg, kind_next;
    logic [31:0] addr_reg, addr_next, wdata_reg, wdata_next;
    logic        last_reg, last_next;

    logic        in_fire, out_free, xfer, down, want, sbit, nbit;
    logic [4:0]  soff_inc, soff_dec, doff_inc;

    assign out_free = !ov_reg || !out_stall;
    assign in_stall = !(state_reg == ST_IDLE || state_reg == ST_WSRC || state_reg == ST_WDST)
                      || ov_reg;
    assign in_fire  = in_valid && !in_stall;
    assign xfer     = oper_reg[3];
    assign down     = oper_reg[0];
    assign want     = oper_reg[1];
    assign sbit     = src_reg[soff_reg];
    assign soff_inc = soff_reg + 5'd1;
    assign soff_dec = soff_reg - 5'd1;
    assign doff_inc = doff_reg + 5'd1;

    always_comb
    begin
        unique case (oper_reg[2:0])
            XF_OR:   nbit = dst_reg[doff_reg] | sbit;
            XF_AND:  nbit = dst_reg[doff_reg] & sbit;
            XF_XOR:  nbit = dst_reg[doff_reg] ^ sbit;
            XF_MOV:  nbit = sbit;
            XF_ORN:  nbit = dst_reg[doff_reg] | !sbit;
            XF_ANDN: nbit = dst_reg[doff_reg] & !sbit;
            XF_XORN: nbit = dst_reg[doff_reg] ^ !sbit;
            XF_NOT:  nbit = !sbit;
            default: nbit = sbit;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;  oper_next = oper_reg;
        src_next = src_reg;  dst_next = dst_reg;  sv_next = sv_reg;  dv_next = dv_reg;
        doff_next = doff_reg;  soff_next = soff_reg;  cnt_next = cnt_reg;
        daddr_next = daddr_reg;  saddr_next = saddr_reg;  skip_next = skip_reg;
        zf_next = zf_reg;
        ov_next = ov_reg && out_stall;
        kind_next = kind_reg;  addr_next = addr_reg;  wdata_next = wdata_reg;
        last_next = last_reg;

        if (in_fire)
        begin
            if (op == OP_START)
            begin
                oper_next  = operation;
                doff_next  = dest_bit_offset;
                soff_next  = source_bit_offset;
                cnt_next   = bit_count;
                daddr_next = dest_word_address & ADDR_MASK;
                saddr_next = source_word_address & ADDR_MASK;
                skip_next  = skipped_start;
                sv_next = 1'b0;  dv_next = 1'b0;
                src_next = '0;  dst_next = '0;
                state_next = ST_RUN;
            end
            else if (state_reg == ST_WSRC)
            begin
                src_next = read_word;  sv_next = 1'b1;  state_next = ST_RUN;
            end
            else if (state_reg == ST_WDST)
            begin
                dst_next = read_word;  dv_next = 1'b1;  state_next = ST_RUN;
            end
        end
        else if (state_reg == ST_OUT)
        begin
            if (!ov_reg)
            begin
                ov_next = 1'b1;  kind_next = KIND_DONE;  addr_next = '0;
                wdata_next = '0;  last_next = 1'b1;  state_next = ST_IDLE;
            end
        end
        else if (state_reg == ST_RUN && out_free)
        begin
            if (cnt_reg == '0)
            begin
                zf_next = !xfer;
                if (xfer && dv_reg)
                begin
                    ov_next = 1'b1;  kind_next = KIND_WRITE;  addr_next = daddr_reg;
                    wdata_next = dst_reg;  last_next = 1'b0;  dv_next = 1'b0;
                    state_next = ST_OUT;
                end
                else
                begin
                    ov_next = 1'b1;  kind_next = KIND_DONE;  addr_next = '0;
                    wdata_next = '0;  last_next = 1'b1;  state_next = ST_IDLE;
                end
            end
            else if (!sv_reg || (xfer && !dv_reg))
            begin
                ov_next = 1'b1;  kind_next = KIND_READ;  wdata_next = '0;
                last_next = 1'b0;
                addr_next  = !sv_reg ? saddr_reg : daddr_reg;
                state_next = !sv_reg ? ST_WSRC : ST_WDST;
            end
            else if (xfer)
            begin
                dst_next[doff_reg] = nbit;
                soff_next = soff_inc;  doff_next = doff_inc;
                cnt_next = cnt_reg - 32'd1;
                if (soff_inc == 5'd0)
                begin
                    saddr_next = saddr_reg + WORD_STEP;  sv_next = 1'b0;
                end
                if (doff_inc == 5'd0)
                begin
                    ov_next = 1'b1;  kind_next = KIND_WRITE;  addr_next = daddr_reg;
                    wdata_next = dst_next;  last_next = 1'b0;
                    daddr_next = daddr_reg + WORD_STEP;  dv_next = 1'b0;
                end
            end
            else if (sbit == want)
            begin
                if (down)
                begin
                    soff_next = soff_inc;
                    if (soff_reg == 5'd31) saddr_next = saddr_reg + WORD_STEP;
                end
                else
                begin
                    soff_next = soff_dec;
                    if (soff_reg == 5'd0) saddr_next = saddr_reg - WORD_STEP;
                end
                zf_next = 1'b0;
                ov_next = 1'b1;  kind_next = KIND_DONE;  addr_next = '0;
                wdata_next = '0;  last_next = 1'b1;  state_next = ST_IDLE;
            end
            else
            begin
                soff_next = down ? soff_dec : soff_inc;
                skip_next = skip_reg + 32'd1;
                cnt_next = cnt_reg - 32'd1;
                if (down && soff_reg == 5'd0)
                begin
                    sv_next = 1'b0;  saddr_next = saddr_reg - WORD_STEP;
                end
                else if (!down && soff_reg == 5'd31)
                begin
                    sv_next = 1'b0;  saddr_next = saddr_reg + WORD_STEP;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;  oper_reg <= '0;  sv_reg <= 1'b0;  dv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;  oper_reg <= oper_next;  sv_reg <= sv_next;
            dv_reg <= dv_next;  ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg <= src_next;  dst_reg <= dst_next;  doff_reg <= doff_next;
        soff_reg <= soff_next;  cnt_reg <= cnt_next;  daddr_reg <= daddr_next;
        saddr_reg <= saddr_next;  skip_reg <= skip_next;  zf_reg <= zf_next;
        kind_reg <= kind_next;  addr_reg <= addr_next;  wdata_reg <= wdata_next;
        last_reg <= last_next;
    end

    assign out_valid   = ov_reg;
    assign kind        = kind_reg;
    assign mem_address = addr_reg;
    assign write_data  = wdata_reg;
    assign last        = last_reg;
    assign final_dest_offset    = last_reg && xfer ? doff_reg : 5'd0;
    assign final_source_offset  = last_reg ? soff_reg : 5'd0;
    assign final_count          = last_reg ? cnt_reg : 32'd0;
    assign final_dest_address   = last_reg && xfer ? daddr_reg : 32'd0;
    assign final_source_address = last_reg ? saddr_reg : 32'd0;
    assign final_skipped        = last_reg && !xfer ? skip_reg : 32'd0;
    assign zero_flag            = last_reg && !xfer && zf_reg;
endmodule
`default_nettype wire

// ===== src/bsms_checker.sv =====
// Port checker for the bit string move and search engine, with its bind.
// Depends on bsms_pkg.
`default_nettype none
module bsms_checker
    import bsms_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [1:0]  kind,
    input wire logic [31:0] mem_address,
    input wire logic        last,
    input wire logic        zero_flag
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(mem_address))
        else $error("stalled result changed");
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == (kind == KIND_DONE)))
        else $error("last does not match done");
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> kind != 2'd3)
        else $error("undefined result kind");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("request taken while a result waits");
    a_zf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> !zero_flag)
        else $error("zero flag on a memory request");
endmodule

bind bit_string_move_and_search_top bsms_checker u_bsms_checker (.*);
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for bit_string_move_and_search_top.
// Drives start and read-data requests, predicts every read, write and done result
// in a local model of the engine, and compares results in order. Depends on bsms_pkg.
`timescale 1ns / 1ps
module tb;
    import bsms_pkg::*;

    localparam logic [3:0] SRCH_DN0 = 4'd1;
    localparam logic [3:0] SRCH_UP1 = 4'd2;
    localparam logic [3:0] SRCH_DN1 = 4'd3;
    localparam int         N_RANDOM = 1520;
    localparam int         CYCLE_LIMIT = 2000000;
    localparam int         PH_IDLE = 0;
    localparam int         PH_SRC = 1;
    localparam int         PH_DST = 2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] addr;
        logic [31:0] wdata;
        logic [4:0]  fdo;
        logic [4:0]  fso;
        logic [31:0] fcnt;
        logic [31:0] fda;
        logic [31:0] fsa;
        logic [31:0] fskip;
        logic        zf;
        logic        last;
    } result_t;

    typedef struct {
        logic        op;
        logic [3:0]  operation;
        logic [4:0]  doff;
        logic [4:0]  soff;
        logic [31:0] cnt;
        logic [31:0] daddr;
        logic [31:0] saddr;
        logic [31:0] skip;
        logic [31:0] word;
        logic        typed;
        logic [1:0]  x_kind;
        logic [31:0] x_addr;
        logic        x_zf;
    } request_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic op = 1'b0;
    logic [3:0] operation = '0;
    logic [4:0] dest_bit_offset = '0;
    logic [4:0] source_bit_offset = '0;
    logic [31:0] bit_count = '0;
    logic [31:0] dest_word_address = '0;
    logic [31:0] source_word_address = '0;
    logic [31:0] skipped_start = '0;
    logic [31:0] read_word = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [1:0] kind;
    logic [31:0] mem_address, write_data, final_count, final_dest_address;
    logic [31:0] final_source_address, final_skipped;
    logic [4:0] final_dest_offset, final_source_offset;
    logic zero_flag, last;

    bit_string_move_and_search_top i_dut (.*);

    always #10 clk = ~clk;

    result_t     pending_q[$];
    int          errors = 0;
    int          cycles = 0;
    int          n_reads = 0, n_writes = 0, n_dones = 0, n_starts = 0;
    bit          idling = 1'b1;
    bit          hold_req = 1'b0;
    request_t    cur;

    int          eng_phase = PH_IDLE;
    logic [3:0]  eng_op;
    logic [31:0] eng_sword, eng_dword, eng_cnt, eng_daddr, eng_saddr, eng_skip;
    logic        eng_sv, eng_dv;
    logic [4:0]  eng_doff, eng_soff;

    function automatic result_t mem_result(logic [1:0] k, logic [31:0] a, logic [31:0] d);
        result_t r;
        r = '0;
        r.kind = k;
        r.addr = a;
        r.wdata = d;
        return r;
    endfunction

    task automatic push_done(bit search, logic zf);
        result_t r;
        r = mem_result(KIND_DONE, '0, '0);
        r.fdo = search ? 5'd0 : eng_doff;
        r.fso = eng_soff;
        r.fcnt = eng_cnt;
        r.fda = search ? 32'd0 : eng_daddr;
        r.fsa = eng_saddr;
        r.fskip = search ? eng_skip : 32'd0;
        r.zf = zf;
        r.last = 1'b1;
        pending_q.push_back(r);
        eng_phase = PH_IDLE;
    endtask

    task automatic run_transfer();
        logic s;
        logic [31:0] m;
        forever
        begin
            if (eng_cnt == 0)
            begin
                if (eng_dv)
                begin
                    pending_q.push_back(mem_result(KIND_WRITE, eng_daddr, eng_dword));
                    eng_dv = 1'b0;
                end
                push_done(1'b0, 1'b0);
                return;
            end
            if (!eng_sv)
            begin
                pending_q.push_back(mem_result(KIND_READ, eng_saddr, '0));
                eng_phase = PH_SRC;
                return;
            end
            if (!eng_dv)
            begin
                pending_q.push_back(mem_result(KIND_READ, eng_daddr, '0));
                eng_phase = PH_DST;
                return;
            end
            s = eng_sword[eng_soff];
            m = 32'd1 << eng_doff;
            case (eng_op[2:0])
                XF_OR:   if (s) eng_dword |= m;
                XF_AND:  if (!s) eng_dword &= ~m;
                XF_XOR:  if (s) eng_dword ^= m;
                XF_MOV:  eng_dword = s ? (eng_dword | m) : (eng_dword & ~m);
                XF_ORN:  if (!s) eng_dword |= m;
                XF_ANDN: if (s) eng_dword &= ~m;
                XF_XORN: if (!s) eng_dword ^= m;
                default: eng_dword = s ? (eng_dword & ~m) : (eng_dword | m);
            endcase
            eng_soff = eng_soff + 5'd1;
            eng_doff = eng_doff + 5'd1;
            eng_cnt = eng_cnt - 1;
            if (eng_soff == 0)
            begin
                eng_saddr = eng_saddr + WORD_STEP;
                eng_sv = 1'b0;
            end
            if (eng_doff == 0)
            begin
                pending_q.push_back(mem_result(KIND_WRITE, eng_daddr, eng_dword));
                eng_daddr = eng_daddr + WORD_STEP;
                eng_dv = 1'b0;
            end
        end
    endtask

    task automatic run_search();
        bit down;
        logic want;
        down = eng_op[0];
        want = eng_op[1];
        forever
        begin
            if (eng_cnt == 0)
            begin
                push_done(1'b1, 1'b1);
                return;
            end
            if (!eng_sv)
            begin
                pending_q.push_back(mem_result(KIND_READ, eng_saddr, '0));
                eng_phase = PH_SRC;
                return;
            end
            if (eng_sword[eng_soff] == want)
            begin
                if (down)
                begin
                    if (eng_soff == 5'd31)
                        eng_saddr = eng_saddr + WORD_STEP;
                    eng_soff = eng_soff + 5'd1;
                end
                else
                begin
                    if (eng_soff == 5'd0)
                        eng_saddr = eng_saddr - WORD_STEP;
                    eng_soff = eng_soff - 5'd1;
                end
                push_done(1'b1, 1'b0);
                return;
            end
            eng_soff = down ? eng_soff - 5'd1 : eng_soff + 5'd1;
            eng_skip = eng_skip + 1;
            eng_cnt = eng_cnt - 1;
            if (eng_soff == (down ? 5'd31 : 5'd0))
            begin
                eng_sv = 1'b0;
                eng_saddr = down ? eng_saddr - WORD_STEP : eng_saddr + WORD_STEP;
            end
        end
    endtask

    task automatic predict_request(request_t r);
        if (r.op == OP_START)
        begin
            n_starts++;
            eng_op = r.operation;
            eng_doff = r.doff;
            eng_soff = r.soff;
            eng_cnt = r.cnt;
            eng_daddr = r.daddr & ADDR_MASK;
            eng_saddr = r.saddr & ADDR_MASK;
            eng_skip = r.skip;
            eng_sv = 1'b0;
            eng_dv = 1'b0;
            eng_sword = '0;
            eng_dword = '0;
        end
        else if (eng_phase == PH_SRC)
        begin
            eng_sword = r.word;
            eng_sv = 1'b1;
        end
        else if (eng_phase == PH_DST)
        begin
            eng_dword = r.word;
            eng_dv = 1'b1;
        end
        else
            return;
        if (eng_op[3])
            run_transfer();
        else
            run_search();
    endtask

    task automatic check_field(string name, logic [31:0] x, logic [31:0] a);
        if (x !== a)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, x, a);
        end
    endtask

    always @(posedge clk)
    begin
        int before_size;
        result_t x;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout", $time);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual kind %0d addr %h",
                         $time, kind, mem_address);
            end
            else
            begin
                x = pending_q.pop_front();
                check_field("kind", 32'(x.kind), 32'(kind));
                check_field("mem_address", x.addr, mem_address);
                check_field("write_data", x.wdata, write_data);
                check_field("final_dest_offset", 32'(x.fdo), 32'(final_dest_offset));
                check_field("final_source_offset", 32'(x.fso), 32'(final_source_offset));
                check_field("final_count", x.fcnt, final_count);
                check_field("final_dest_address", x.fda, final_dest_address);
                check_field("final_source_address", x.fsa, final_source_address);
                check_field("final_skipped", x.fskip, final_skipped);
                check_field("zero_flag", 32'(x.zf), 32'(zero_flag));
                check_field("last", 32'(x.last), 32'(last));
                case (x.kind)
                    KIND_READ:  n_reads++;
                    KIND_WRITE: n_writes++;
                    default:    n_dones++;
                endcase
            end
        end
        if (rst_n && in_valid && !in_stall)
        begin
            before_size = pending_q.size();
            predict_request(cur);
            if (cur.typed)
            begin
                if (pending_q.size() == before_size)
                begin
                    errors++;
                    $display("%0t: expected kind %0d, actual no result predicted",
                             $time, cur.x_kind);
                end
                else
                begin
                    x = pending_q[before_size];
                    check_field("typed kind", 32'(cur.x_kind), 32'(x.kind));
                    check_field("typed address", cur.x_addr, x.addr);
                    check_field("typed zero_flag", 32'(cur.x_zf), 32'(x.zf));
                end
            end
        end
    end

    always @(negedge clk)
    begin
        int k;
        if (hold_req)
        begin
            out_stall <= 1'b1;
            for (k = 0; k < 400; k++)
                @(negedge clk);
            hold_req = 1'b0;
            out_stall <= 1'b0;
        end
        else if (idling && $urandom_range(0, 7) == 0)
        begin
            out_stall <= 1'b1;
            repeat ($urandom_range(1, 18)) @(negedge clk);
            out_stall <= 1'b0;
        end
    end

    task automatic send(request_t r);
        if (idling && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        cur = r;
        op <= r.op;
        operation <= r.operation;
        dest_bit_offset <= r.doff;
        source_bit_offset <= r.soff;
        bit_count <= r.cnt;
        dest_word_address <= r.daddr;
        source_word_address <= r.saddr;
        skipped_start <= r.skip;
        read_word <= r.word;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        @(negedge clk);
    endtask

    function automatic request_t row(logic o, logic [3:0] opn, logic [4:0] d, logic [4:0] s,
                                     logic [31:0] c, logic [31:0] da, logic [31:0] sa,
                                     logic [31:0] sk, logic [31:0] w);
        request_t r;
        r = '{o, opn, d, s, c, da, sa, sk, w, 1'b0, KIND_READ, 32'd0, 1'b0};
        return r;
    endfunction

    function automatic request_t typed_row(request_t r, logic [1:0] k, logic [31:0] a,
                                           logic z);
        r.typed = 1'b1;
        r.x_kind = k;
        r.x_addr = a;
        r.x_zf = z;
        return r;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h1 << $urandom_range(0, 31);
            3:       return ~(32'h1 << $urandom_range(0, 31));
            default: return $urandom;
        endcase
    endfunction

    function automatic request_t rand_start();
        logic [31:0] c;
        case ($urandom_range(0, 9))
            0:       c = 32'd0;
            1:       c = $urandom;
            2:       c = 32'hFFFF_FFFF;
            3, 4:    c = $urandom_range(33, 200);
            default: c = $urandom_range(1, 40);
        endcase
        return row(OP_START, 4'($urandom), 5'($urandom), 5'($urandom), c, $urandom,
                   $urandom, $urandom, $urandom);
    endfunction

    request_t table_rows[$];

    initial
    begin
        int i, burst, n_items;
        bit held, drained;
        held = 1'b0;
        drained = 1'b0;
        table_rows.push_back(typed_row(row(OP_START, {1'b1, XF_OR}, 5'd31, 5'd0, 32'd0,
            32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0), KIND_DONE, 32'd0, 1'b0));
        table_rows.push_back(typed_row(row(OP_START, SRCH_UP1, 5'd0, 5'd7, 32'd0,
            32'd0, 32'h40, 32'hFFFF_FFFF, 32'd0), KIND_DONE, 32'd0, 1'b1));
        table_rows.push_back(typed_row(row(OP_START, SRCH_UP1, 5'd0, 5'd31, 32'hFFFF_FFFF,
            32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0), KIND_READ, 32'hFFFF_FFFC, 1'b0));
        table_rows.push_back(typed_row(row(OP_DATA, 4'd0, 5'd0, 5'd0, 32'd0, 32'd0, 32'd0,
            32'd0, 32'h8000_0000), KIND_DONE, 32'd0, 1'b0));
        table_rows.push_back(typed_row(row(OP_START, SRCH_DN0, 5'd0, 5'd0, 32'd40,
            32'd0, 32'h103, 32'd0, 32'd0), KIND_READ, 32'h100, 1'b0));
        table_rows.push_back(typed_row(row(OP_DATA, 4'd0, 5'd0, 5'd0, 32'd0, 32'd0, 32'd0,
            32'd0, 32'hFFFF_FFFF), KIND_READ, 32'hFC, 1'b0));
        table_rows.push_back(typed_row(row(OP_DATA, 4'd0, 5'd0, 5'd0, 32'd0, 32'd0, 32'd0,
            32'd0, 32'h7FFF_FFFF), KIND_DONE, 32'd0, 1'b0));
        table_rows.push_back(row(OP_DATA, 4'hF, 5'd31, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1234_5678));
        table_rows.push_back(row(OP_START, SRCH_DN1, 5'd0, 5'd5, 32'd100, 32'd0, 32'h2000,
            32'd0, 32'd0));
        for (i = 0; i < 8; i++)
        begin
            table_rows.push_back(row(OP_START, {1'b1, 3'(i)}, 5'd30, 5'd3, 32'd5,
                32'h1000, 32'h2000, 32'd0, 32'd0));
            table_rows.push_back(row(OP_DATA, 4'd0, 5'd0, 5'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                32'hA5C3_0F96));
            table_rows.push_back(row(OP_DATA, 4'd0, 5'd0, 5'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                32'h5A3C_F069));
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (table_rows[j])
            send(table_rows[j]);

        n_items = 0;
        while (n_items < N_RANDOM)
        begin
            if (!held && n_items >= 500)
            begin
                held = 1'b1;
                hold_req = 1'b1;
            end
            if (!drained && n_items >= 900)
            begin
                drained = 1'b1;
                in_valid <= 1'b0;
                while (pending_q.size() != 0)
                    @(negedge clk);
            end
            if (n_items > N_RANDOM - 200)
                idling = 1'b0;
            send(rand_start());
            n_items++;
            burst = $urandom_range(1, 40);
            while (eng_phase != PH_IDLE && burst > 0)
            begin
                send(row(OP_DATA, 4'($urandom), 5'($urandom), 5'($urandom), $urandom,
                         $urandom, $urandom, $urandom, rand_word()));
                n_items++;
                burst--;
            end
            if ($urandom_range(0, 9) == 0)
                send(row(OP_DATA, 4'($urandom), 5'($urandom), 5'($urandom), $urandom,
                         $urandom, $urandom, $urandom, $urandom));
        end

        in_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        if (pending_q.size() != 0)
        begin
            errors++;
            $display("%0t: %0d results never arrived", $time, pending_q.size());
        end
        $display("Covered %0d starts with %0d reads, %0d writes and %0d completions.",
                 n_starts, n_reads, n_writes, n_dones);
        $display("All eight transfer operations and four search modes were exercised.");
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
